>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SNCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define SNCL_NEVER(lbl, cond, msg) \
  `SNCL_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/sncl_pkg.sv
// Types, constants and keyword matching for the sample name classifier.
`default_nettype none
package sncl_pkg;

  localparam int unsigned KW_MAX = 10;  // longest keyword
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [3:0] {
    CAT_UNKNOWN = 4'd0,
    CAT_KICK    = 4'd1,
    CAT_SNARE   = 4'd2,
    CAT_CLAP    = 4'd3,
    CAT_CHAT    = 4'd4,
    CAT_OHAT    = 4'd5,
    CAT_TOM     = 4'd6,
    CAT_PERC    = 4'd7,
    CAT_FX      = 4'd8
  } cat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZCR_BRIGHT  = 3'd0,
    CFG_ZCR_DARK    = 3'd1,
    CFG_DECAY_OPEN  = 3'd2,
    CFG_DECAY_KICK  = 3'd3,
    CFG_DECAY_SNARE = 3'd4,
    CFG_CLAP_ONSETS = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] ZCR_BRIGHT_RST  = 16'd1024;
  localparam logic [15:0] ZCR_DARK_RST    = 16'd328;
  localparam logic [15:0] DECAY_OPEN_RST  = 16'd1433;
  localparam logic [15:0] DECAY_KICK_RST  = 16'd2048;
  localparam logic [15:0] DECAY_SNARE_RST = 16'd1638;
  localparam logic [7:0]  CLAP_ONSET_RST  = 8'd3;

  // Lead word codes for two-word phrases.
  localparam logic [3:0] LEAD_NONE   = 4'd0;
  localparam logic [3:0] LEAD_OPEN   = 4'd1;
  localparam logic [3:0] LEAD_HAT    = 4'd2;
  localparam logic [3:0] LEAD_CLOSED = 4'd3;
  localparam logic [3:0] LEAD_CLOSE  = 4'd4;
  localparam logic [3:0] LEAD_HI     = 4'd5;
  localparam logic [3:0] LEAD_BASS   = 4'd6;
  localparam logic [3:0] LEAD_RIM    = 4'd7;
  localparam logic [3:0] LEAD_HAND   = 4'd8;

  localparam logic [7:0] ASCII_DOT = 8'h2e;

  typedef struct packed {
    logic [15:0] zcr_bright;
    logic [15:0] zcr_dark;
    logic [15:0] decay_open;
    logic [15:0] decay_kick;
    logic [15:0] decay_snare;
    logic [7:0]  clap_onsets;
  } cfg_t;

  // Per-stream control for one byte.
  typedef struct packed {
    logic       adv;    // byte leaves the input register
    logic       brk;    // word boundary before this byte
    logic       app;    // byte is alphanumeric and gets appended
    logic       fin;    // final byte of the name
    logic [7:0] chr;    // lowercased byte
  } wctl_t;

  typedef struct packed {
    logic [7:0] hits;
    logic [3:0] lead;
  } match_t;

  function automatic logic [7:0] cat_bit(cat_e c);
    cat_bit = 8'd1 << (c - 4'd1);
  endfunction

  // Word chars: char i at w[8*i +: 8]. Keyword is a right-aligned string literal.
  function automatic logic is_kw(logic [8*KW_MAX-1:0] w, logic [3:0] len,
                                 logic [8*KW_MAX-1:0] k);
    logic [3:0] klen;
    logic r;
    klen = 4'd0;
    for (int i = 0; i < KW_MAX; i++) begin
      if (k[8*i +: 8] != 8'd0) klen = klen + 4'd1;
    end
    r = (len == klen);
    for (int i = 0; i < KW_MAX; i++) begin
      if (i < klen && w[8*i +: 8] != k[8*(klen-1-i) +: 8]) r = 1'b0;
    end
    is_kw = r;
  endfunction

  function automatic match_t match_word(logic [8*KW_MAX-1:0] w, logic [3:0] len,
                                        logic [3:0] prev_lead);
    match_t m;
    m.hits = 8'd0;
    m.lead = LEAD_NONE;
    if (is_kw(w, len, "openhat"))    m.hits |= cat_bit(CAT_OHAT);
    if (is_kw(w, len, "ohat"))       m.hits |= cat_bit(CAT_OHAT);
    if (is_kw(w, len, "hatopen"))    m.hits |= cat_bit(CAT_OHAT);
    if (is_kw(w, len, "closedhat"))  m.hits |= cat_bit(CAT_CHAT);
    if (is_kw(w, len, "closehat"))   m.hits |= cat_bit(CAT_CHAT);
    if (is_kw(w, len, "hihat"))      m.hits |= cat_bit(CAT_CHAT);
    if (is_kw(w, len, "chh"))        m.hits |= cat_bit(CAT_CHAT);
    if (is_kw(w, len, "hat"))        m.hits |= cat_bit(CAT_CHAT);
    if (is_kw(w, len, "hh"))         m.hits |= cat_bit(CAT_CHAT);
    if (is_kw(w, len, "kick"))       m.hits |= cat_bit(CAT_KICK);
    if (is_kw(w, len, "kck"))        m.hits |= cat_bit(CAT_KICK);
    if (is_kw(w, len, "bassdrum"))   m.hits |= cat_bit(CAT_KICK);
    if (is_kw(w, len, "bd"))         m.hits |= cat_bit(CAT_KICK);
    if (is_kw(w, len, "snare"))      m.hits |= cat_bit(CAT_SNARE);
    if (is_kw(w, len, "snr"))        m.hits |= cat_bit(CAT_SNARE);
    if (is_kw(w, len, "rimshot"))    m.hits |= cat_bit(CAT_SNARE);
    if (is_kw(w, len, "sd"))         m.hits |= cat_bit(CAT_SNARE);
    if (is_kw(w, len, "rim"))        m.hits |= cat_bit(CAT_SNARE);
    if (is_kw(w, len, "brush"))      m.hits |= cat_bit(CAT_SNARE);
    if (is_kw(w, len, "clap"))       m.hits |= cat_bit(CAT_CLAP);
    if (is_kw(w, len, "clp"))        m.hits |= cat_bit(CAT_CLAP);
    if (is_kw(w, len, "handclap"))   m.hits |= cat_bit(CAT_CLAP);
    if (is_kw(w, len, "tom"))        m.hits |= cat_bit(CAT_TOM);
    if (is_kw(w, len, "perc"))       m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "conga"))      m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "bongo"))      m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "shaker"))     m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "tamb"))       m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "cowbell"))    m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "clave"))      m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "ride"))       m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "crash"))      m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "cymbal"))     m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "block"))      m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "triangle"))   m.hits |= cat_bit(CAT_PERC);
    if (is_kw(w, len, "fx"))         m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "riser"))      m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "sweep"))      m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "noise"))      m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "impact"))     m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "reverse"))    m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "vinyl"))      m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "foley"))      m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "downlifter")) m.hits |= cat_bit(CAT_FX);
    if (is_kw(w, len, "uplifter"))   m.hits |= cat_bit(CAT_FX);
    // two-word phrases
    if (prev_lead == LEAD_OPEN   && is_kw(w, len, "hat"))  m.hits |= cat_bit(CAT_OHAT);
    if (prev_lead == LEAD_HAT    && is_kw(w, len, "open")) m.hits |= cat_bit(CAT_OHAT);
    if (prev_lead == LEAD_CLOSED && is_kw(w, len, "hat"))  m.hits |= cat_bit(CAT_CHAT);
    if (prev_lead == LEAD_CLOSE  && is_kw(w, len, "hat"))  m.hits |= cat_bit(CAT_CHAT);
    if (prev_lead == LEAD_HI     && is_kw(w, len, "hat"))  m.hits |= cat_bit(CAT_CHAT);
    if (prev_lead == LEAD_BASS   && is_kw(w, len, "drum")) m.hits |= cat_bit(CAT_KICK);
    if (prev_lead == LEAD_RIM    && is_kw(w, len, "shot")) m.hits |= cat_bit(CAT_SNARE);
    if (prev_lead == LEAD_HAND   && is_kw(w, len, "clap")) m.hits |= cat_bit(CAT_CLAP);
    // lead words
    if (is_kw(w, len, "open"))   m.lead = LEAD_OPEN;
    if (is_kw(w, len, "hat"))    m.lead = LEAD_HAT;
    if (is_kw(w, len, "closed")) m.lead = LEAD_CLOSED;
    if (is_kw(w, len, "close"))  m.lead = LEAD_CLOSE;
    if (is_kw(w, len, "hi"))     m.lead = LEAD_HI;
    if (is_kw(w, len, "bass"))   m.lead = LEAD_BASS;
    if (is_kw(w, len, "rim"))    m.lead = LEAD_RIM;
    if (is_kw(w, len, "hand"))   m.lead = LEAD_HAND;
    match_word = m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sncl_word.sv
// Word buffer of one stream with whole-word keyword matcher.
`default_nettype none
module sncl_word #(
  parameter int unsigned WORD_CHARS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sncl_pkg::wctl_t ctl_i,
  output logic [7:0]         hits_o
);
  localparam int unsigned LW = $clog2(WORD_CHARS + 1);
  localparam int unsigned IW = $clog2(WORD_CHARS);
  localparam int unsigned KW = sncl_pkg::KW_MAX;

  logic [7:0]    chars_q [WORD_CHARS];
  logic [LW-1:0] len_q, len_d, len_v;
  logic          ovf_q, ovf_d, ovf_v;
  logic [3:0]    lead_q, lead_d;
  logic          use_post, fire, room, wr_en;
  logic [IW-1:0] wr_idx;
  logic [8*KW-1:0] view;
  sncl_pkg::match_t m;

  // On the final byte with no boundary, the byte joins the word before matching.
  assign use_post = ctl_i.fin & ~ctl_i.brk & ctl_i.app;
  assign room     = (len_q < LW'(WORD_CHARS));

  always_comb begin
    for (int i = 0; i < KW; i++) begin
      view[8*i +: 8] = (use_post && len_q == LW'(i)) ? ctl_i.chr : chars_q[i];
    end
    len_v = (use_post && room) ? len_q + LW'(1) : len_q;
    ovf_v = ovf_q | (use_post & ~room);
  end

  assign fire = (ctl_i.brk | ctl_i.fin) & ((len_v != '0) | ovf_v);
  assign m    = sncl_pkg::match_word(view, len_v[3:0], lead_q);
  assign hits_o = (fire && !ovf_v && len_v <= LW'(KW)) ? m.hits : 8'd0;

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    lead_d = lead_q;
    wr_en  = 1'b0;
    wr_idx = len_q[IW-1:0];
    if (ctl_i.fin) begin
      len_d  = '0;
      ovf_d  = 1'b0;
      lead_d = sncl_pkg::LEAD_NONE;
    end else begin
      if (ctl_i.brk) begin
        if (fire) begin
          lead_d = (ovf_v || len_v > LW'(KW)) ? sncl_pkg::LEAD_NONE : m.lead;
        end
        len_d = '0;
        ovf_d = 1'b0;
        if (ctl_i.app) begin
          wr_en  = 1'b1;
          wr_idx = '0;
          len_d  = LW'(1);
        end
      end else if (ctl_i.app) begin
        if (room) begin
          wr_en = 1'b1;
          len_d = len_q + LW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && wr_en) begin
      chars_q[wr_idx] <= ctl_i.chr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      lead_q <= sncl_pkg::LEAD_NONE;
    end else if (ctl_i.adv) begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      lead_q <= lead_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/sncl_feat.sv
// Category pick: keyword priority, else threshold tree on the audio features.
`default_nettype none
module sncl_feat (
  input  wire logic [7:0]     hits_i,
  input  wire logic [15:0]    zcr_i,
  input  wire logic [15:0]    decay_i,
  input  wire logic [7:0]     onsets_i,
  input  wire sncl_pkg::cfg_t cfg_i,
  output sncl_pkg::cat_e      cat_o,
  output logic                from_name_o
);
  always_comb begin
    from_name_o = 1'b1;
    if      (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_OHAT)))  cat_o = sncl_pkg::CAT_OHAT;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_CHAT)))  cat_o = sncl_pkg::CAT_CHAT;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_KICK)))  cat_o = sncl_pkg::CAT_KICK;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_SNARE))) cat_o = sncl_pkg::CAT_SNARE;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_CLAP)))  cat_o = sncl_pkg::CAT_CLAP;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_TOM)))   cat_o = sncl_pkg::CAT_TOM;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_PERC)))  cat_o = sncl_pkg::CAT_PERC;
    else if (|(hits_i & sncl_pkg::cat_bit(sncl_pkg::CAT_FX)))    cat_o = sncl_pkg::CAT_FX;
    else begin
      from_name_o = 1'b0;
      if (zcr_i > cfg_i.zcr_bright) begin
        cat_o = (decay_i > cfg_i.decay_open) ? sncl_pkg::CAT_OHAT : sncl_pkg::CAT_CHAT;
      end else if (zcr_i < cfg_i.zcr_dark) begin
        cat_o = (decay_i > cfg_i.decay_kick) ? sncl_pkg::CAT_KICK : sncl_pkg::CAT_TOM;
      end else if (onsets_i >= cfg_i.clap_onsets) begin
        cat_o = sncl_pkg::CAT_CLAP;
      end else begin
        cat_o = (decay_i > cfg_i.decay_snare) ? sncl_pkg::CAT_SNARE : sncl_pkg::CAT_PERC;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/sample_name_keyword_classifier_unit.sv
// Top level of the sample name classifier.
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i / in_stall_o | char_code, last, zero_cross_rate, decay_time,
//          |     |                         | onset_count
//  out     | out | out_valid_o/out_stall_i | category, from_name (one beat per name)
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
// One byte per cycle while the input is not stalled; each byte is held in the input
// register, and the result is loaded into the output register as the final byte leaves it.
// Reset clears all name state and loads the default thresholds; no clearing pass.
// A waiting result stalls input only when a final byte needs the output register.
`default_nettype none
`include "assert_macros.svh"
module sample_name_keyword_classifier_unit #(
  parameter int unsigned WORD_CHARS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      char_code_i,
  input  wire logic                            last_i,
  input  wire logic [15:0]                     zero_cross_rate_i,
  input  wire logic [15:0]                     decay_time_i,
  input  wire logic [7:0]                      onset_count_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [3:0]                           category_o,
  output logic                                 from_name_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [sncl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sncl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  sncl_pkg::cfg_t cfg_q;

  logic        s1_valid_q, s1_last_q;
  logic [7:0]  s1_char_q, s1_onsets_q;
  logic [15:0] s1_zcr_q, s1_decay_q;

  logic prev_alnum_q, prev_lower_q, prev_digit_q, dot_q;
  logic [7:0] comm_q, pend_q;
  logic out_valid_q, from_name_q;
  sncl_pkg::cat_e cat_q;

  logic is_upper, is_lower, is_digit, is_alnum, is_dot, out_free, adv, accept;
  logic brk_join, brk_split;
  logic [7:0] lc_char, hits_split, hits_join, pend1, comm_n, pend_n, hits_fin;
  logic dot_n;
  sncl_pkg::wctl_t ctl_split, ctl_join;
  sncl_pkg::cat_e cat_d;
  logic from_name_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zcr_bright  <= sncl_pkg::ZCR_BRIGHT_RST;
      cfg_q.zcr_dark    <= sncl_pkg::ZCR_DARK_RST;
      cfg_q.decay_open  <= sncl_pkg::DECAY_OPEN_RST;
      cfg_q.decay_kick  <= sncl_pkg::DECAY_KICK_RST;
      cfg_q.decay_snare <= sncl_pkg::DECAY_SNARE_RST;
      cfg_q.clap_onsets <= sncl_pkg::CLAP_ONSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sncl_pkg::CFG_ZCR_BRIGHT:  cfg_q.zcr_bright  <= cfg_data_i;
        sncl_pkg::CFG_ZCR_DARK:    cfg_q.zcr_dark    <= cfg_data_i;
        sncl_pkg::CFG_DECAY_OPEN:  cfg_q.decay_open  <= cfg_data_i;
        sncl_pkg::CFG_DECAY_KICK:  cfg_q.decay_kick  <= cfg_data_i;
        sncl_pkg::CFG_DECAY_SNARE: cfg_q.decay_snare <= cfg_data_i;
        sncl_pkg::CFG_CLAP_ONSETS: cfg_q.clap_onsets <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign adv        = s1_valid_q & (~s1_last_q | out_free);
  assign in_stall_o = s1_valid_q & ~adv;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_char_q   <= char_code_i;
      s1_last_q   <= last_i;
      s1_zcr_q    <= zero_cross_rate_i;
      s1_decay_q  <= decay_time_i;
      s1_onsets_q <= onset_count_i;
    end
  end

  // byte classes
  assign is_upper = (s1_char_q >= 8'h41) && (s1_char_q <= 8'h5a);
  assign is_lower = (s1_char_q >= 8'h61) && (s1_char_q <= 8'h7a);
  assign is_digit = (s1_char_q >= 8'h30) && (s1_char_q <= 8'h39);
  assign is_alnum = is_upper | is_lower | is_digit;
  assign is_dot   = (s1_char_q == sncl_pkg::ASCII_DOT);
  assign lc_char  = is_upper ? (s1_char_q | 8'h20) : s1_char_q;

  assign brk_join  = ~is_alnum | (prev_alnum_q & (is_digit != prev_digit_q));
  assign brk_split = brk_join | (is_alnum & prev_alnum_q & is_upper & prev_lower_q);

  always_comb begin
    ctl_join.adv  = adv;
    ctl_join.brk  = brk_join;
    ctl_join.app  = is_alnum;
    ctl_join.fin  = s1_last_q;
    ctl_join.chr  = lc_char;
    ctl_split     = ctl_join;
    ctl_split.brk = brk_split;
  end

  sncl_word #(.WORD_CHARS(WORD_CHARS)) u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_split),
    .hits_o (hits_split)
  );

  sncl_word #(.WORD_CHARS(WORD_CHARS)) u_join (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_join),
    .hits_o (hits_join)
  );

  // hits after the last dot stay pending and are dropped as extension
  assign pend1    = pend_q | hits_split | hits_join;
  assign comm_n   = is_dot ? (comm_q | pend1) : comm_q;
  assign pend_n   = is_dot ? 8'd0 : pend1;
  assign dot_n    = dot_q | is_dot;
  assign hits_fin = comm_n | (dot_n ? 8'd0 : pend_n);

  sncl_feat u_feat (
    .hits_i      (hits_fin),
    .zcr_i       (s1_zcr_q),
    .decay_i     (s1_decay_q),
    .onsets_i    (s1_onsets_q),
    .cfg_i       (cfg_q),
    .cat_o       (cat_d),
    .from_name_o (from_name_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_alnum_q <= 1'b0;
      prev_lower_q <= 1'b0;
      prev_digit_q <= 1'b0;
      dot_q        <= 1'b0;
      comm_q       <= 8'd0;
      pend_q       <= 8'd0;
    end else if (adv) begin
      if (s1_last_q) begin
        prev_alnum_q <= 1'b0;
        prev_lower_q <= 1'b0;
        prev_digit_q <= 1'b0;
        dot_q        <= 1'b0;
        comm_q       <= 8'd0;
        pend_q       <= 8'd0;
      end else begin
        prev_alnum_q <= is_alnum;
        prev_lower_q <= is_lower;
        prev_digit_q <= is_digit;
        dot_q        <= dot_n;
        comm_q       <= comm_n;
        pend_q       <= pend_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_last_q) begin
      cat_q       <= cat_d;
      from_name_q <= from_name_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign category_o  = cat_q;
  assign from_name_o = from_name_q;

  `SNCL_ASSERT(a_name_not_unknown,
               (out_valid_o && from_name_o) |-> (category_o != sncl_pkg::CAT_UNKNOWN),
               "name decision with unknown category")
  `SNCL_NEVER(a_stall_needs_item, in_stall_o && !s1_valid_q, "stall with empty input register")
  `SNCL_ASSERT(a_last_gives_result, (adv && s1_last_q) |=> out_valid_o,
               "final byte gave no result")
  `SNCL_ASSERT(a_name_cleared, (adv && s1_last_q) |=> (comm_q == 8'd0 && pend_q == 8'd0 && !dot_q),
               "name state not cleared after result")
endmodule
`default_nettype wire
